// ===== hw/rtl/bstl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_pkg
// shared types and constants of the bottom-stack tile layout block
// ----------------------------------------------------------------------------
package bstl_pkg;

	localparam int MAX_WINDOWS = 16;
	localparam int CNT_W       = 5;
	localparam int COORD_W     = 10;
	localparam int POS_Y_W     = 11;
	localparam int IDX_W       = 4;
	localparam int FRAC_W      = 8;
	localparam int PROD_W      = FRAC_W + COORD_W;
	localparam int NX_W        = COORD_W + 2;
	localparam int CFG_ADDR_W  = 3;
	localparam int DIV_CNT_W   = $clog2(COORD_W + 1);

	localparam logic [COORD_W-1:0] RST_AREA_X          = COORD_W'(0);
	localparam logic [COORD_W-1:0] RST_AREA_Y          = COORD_W'(1);
	localparam logic [COORD_W-1:0] RST_AREA_W          = COORD_W'(80);
	localparam logic [COORD_W-1:0] RST_AREA_H          = COORD_W'(24);
	localparam logic [CNT_W-1:0]   RST_MASTER_COUNT    = CNT_W'(1);
	localparam logic [FRAC_W-1:0]  RST_MASTER_FRACTION = FRAC_W'(128);

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_WINDOW = 2'd1,
		KIND_SEP    = 2'd2,
		KIND_CROSS  = 2'd3
	} kind_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_AREA_X          = 3'd0,
		REG_AREA_Y          = 3'd1,
		REG_AREA_W          = 3'd2,
		REG_AREA_H          = 3'd3,
		REG_MASTER_COUNT    = 3'd4,
		REG_MASTER_FRACTION = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_SETUP,
		ST_DIV_M,
		ST_DIV_T,
		ST_WIN,
		ST_SEP,
		ST_CROSS
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] area_x;
		logic [COORD_W-1:0] area_y;
		logic [COORD_W-1:0] area_w;
		logic [COORD_W-1:0] area_h;
		logic [CNT_W-1:0]   master_count;
		logic [FRAC_W-1:0]  master_fraction;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_start;
		logic div_sel_tile;
		logic cap_mw;
		logic cap_tw;
		logic emit_zero;
		logic emit_sep;
		logic emit_win;
		logic emit_cross;
	} dp_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic emit_ok;
		logic div_done;
		logic has_tiles;
		logic win_last;
		logic next_row_start;
		logic cross_needed;
		logic cross_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bstl_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_regs
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module bstl_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bstl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [bstl_pkg::COORD_W-1:0]        cfg_wdata,
	output bstl_pkg::cfg_t                           cfg
);

	bstl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_x          <= bstl_pkg::RST_AREA_X;
			cfg_q.area_y          <= bstl_pkg::RST_AREA_Y;
			cfg_q.area_w          <= bstl_pkg::RST_AREA_W;
			cfg_q.area_h          <= bstl_pkg::RST_AREA_H;
			cfg_q.master_count    <= bstl_pkg::RST_MASTER_COUNT;
			cfg_q.master_fraction <= bstl_pkg::RST_MASTER_FRACTION;
		end else if (cfg_we) begin
			unique case (bstl_pkg::reg_idx_t'(cfg_addr))
				bstl_pkg::REG_AREA_X:          cfg_q.area_x <= cfg_wdata;
				bstl_pkg::REG_AREA_Y:          cfg_q.area_y <= cfg_wdata;
				bstl_pkg::REG_AREA_W:          cfg_q.area_w <= cfg_wdata;
				bstl_pkg::REG_AREA_H:          cfg_q.area_h <= cfg_wdata;
				bstl_pkg::REG_MASTER_COUNT:
					cfg_q.master_count <= cfg_wdata[bstl_pkg::CNT_W-1:0];
				bstl_pkg::REG_MASTER_FRACTION:
					cfg_q.master_fraction <= cfg_wdata[bstl_pkg::FRAC_W-1:0];
				default: ; // unused index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bstl_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bstl_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [bstl_pkg::COORD_W-1:0]   dividend,
	input  wire logic [bstl_pkg::CNT_W-1:0]     divisor,
	output logic                                done,
	output logic [bstl_pkg::COORD_W-1:0]        quotient
);

	logic [bstl_pkg::COORD_W-1:0]   q_q;
	logic [bstl_pkg::CNT_W-1:0]     r_q;
	logic [bstl_pkg::CNT_W-1:0]     d_q;
	logic [bstl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [bstl_pkg::CNT_W:0]       trial;
	logic [bstl_pkg::CNT_W:0]       diff;
	logic                           ge;

	always_comb begin
		trial = {r_q, q_q[bstl_pkg::COORD_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == bstl_pkg::DIV_CNT_W'(1));
			if (start)
				cnt_q <= bstl_pkg::DIV_CNT_W'(bstl_pkg::COORD_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder always stays below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			r_q <= ge ? diff[bstl_pkg::CNT_W-1:0] : trial[bstl_pkg::CNT_W-1:0];
			q_q <= {q_q[bstl_pkg::COORD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bstl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_ctrl
// sequencer: setup, one or two divisions, then, while the output can take it, one result per cycle
// ----------------------------------------------------------------------------
module bstl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bstl_pkg::dp_sts_t  sts,
	output bstl_pkg::dp_cmd_t       cmd
);

	bstl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bstl_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bstl_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = sts.in_zero ? bstl_pkg::ST_ZERO : bstl_pkg::ST_SETUP;
			end
			bstl_pkg::ST_ZERO: begin
				if (sts.emit_ok)
					state_d = bstl_pkg::ST_IDLE;
			end
			bstl_pkg::ST_SETUP: state_d = bstl_pkg::ST_DIV_M;
			bstl_pkg::ST_DIV_M: begin
				if (sts.div_done)
					state_d = sts.has_tiles ? bstl_pkg::ST_DIV_T : bstl_pkg::ST_WIN;
			end
			bstl_pkg::ST_DIV_T: begin
				if (sts.div_done)
					state_d = bstl_pkg::ST_WIN;
			end
			bstl_pkg::ST_WIN: begin
				if (sts.emit_ok) begin
					priority if (sts.win_last)
						state_d = sts.cross_needed ? bstl_pkg::ST_CROSS : bstl_pkg::ST_IDLE;
					else if (sts.next_row_start)
						state_d = bstl_pkg::ST_WIN;
					else
						state_d = bstl_pkg::ST_SEP;
				end
			end
			bstl_pkg::ST_SEP: begin
				if (sts.emit_ok)
					state_d = bstl_pkg::ST_WIN;
			end
			bstl_pkg::ST_CROSS: begin
				if (sts.emit_ok && sts.cross_last)
					state_d = bstl_pkg::ST_IDLE;
			end
			default: state_d = bstl_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bstl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			bstl_pkg::ST_ZERO:  cmd.emit_zero = sts.emit_ok;
			bstl_pkg::ST_SETUP: begin
				cmd.setup     = 1'b1;
				cmd.div_start = 1'b1;
			end
			bstl_pkg::ST_DIV_M: begin
				cmd.cap_mw       = sts.div_done;
				cmd.div_start    = sts.div_done && sts.has_tiles;
				cmd.div_sel_tile = 1'b1;
			end
			bstl_pkg::ST_DIV_T: cmd.cap_tw = sts.div_done;
			bstl_pkg::ST_WIN:   cmd.emit_win = sts.emit_ok;
			bstl_pkg::ST_SEP:   cmd.emit_sep = sts.emit_ok;
			bstl_pkg::ST_CROSS: cmd.emit_cross = sts.emit_ok;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bstl_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstl_dp
// layout datapath: counts, row heights, widths, walking column, result register
// ----------------------------------------------------------------------------
module bstl_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire bstl_pkg::cfg_t                       cfg,
	input  wire logic [bstl_pkg::CNT_W-1:0]           window_count,
	input  wire bstl_pkg::dp_cmd_t                    cmd,
	output bstl_pkg::dp_sts_t                         sts,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [1:0]                                kind,
	output logic [bstl_pkg::IDX_W-1:0]                window_index,
	output logic [bstl_pkg::COORD_W-1:0]              pos_x,
	output logic signed [bstl_pkg::POS_Y_W-1:0]       pos_y,
	output logic [bstl_pkg::COORD_W-1:0]              width,
	output logic [bstl_pkg::COORD_W-1:0]              height,
	output logic                                      last
);

	localparam int CW = bstl_pkg::COORD_W;
	localparam int NW = bstl_pkg::CNT_W;
	localparam int XW = bstl_pkg::NX_W;
	localparam int YW = bstl_pkg::POS_Y_W;

	logic [NW-1:0] n_q, m_q, i_q;
	logic [CW-1:0] mh_q, mw_q, tw_q;
	logic [XW-1:0] nx_q;

	logic [NW-1:0]                  n_sat, m_min, m_clamp, div_d;
	logic [bstl_pkg::PROD_W-1:0]    prod;
	logic [CW-1:0]                  quot;
	logic                           div_done;
	logic                           in_tile, has_tiles, row_last, win_last;
	logic                           next_row_start, cross_needed, cross_last;
	logic [CW:0]                    end_x;
	logic signed [XW:0]             rem_w;
	logic [CW-1:0]                  nw_sat, nw;
	logic [YW-1:0]                  ay, tile_y, row_y;
	logic [CW-1:0]                  row_h;
	logic                           emit, emit_ok;

	logic                           out_valid_q;
	bstl_pkg::kind_t                kind_q;
	logic [bstl_pkg::IDX_W-1:0]     idx_q;
	logic [CW-1:0]                  pos_x_q, width_q, height_q;
	logic [YW-1:0]                  pos_y_q;
	logic                           last_q;

	always_comb begin
		n_sat   = (window_count > NW'(bstl_pkg::MAX_WINDOWS)) ?
			NW'(bstl_pkg::MAX_WINDOWS) : window_count;
		m_min   = (cfg.master_count > n_sat) ? n_sat : cfg.master_count;
		m_clamp = (m_min == '0) ? NW'(1) : m_min;
		prod    = bstl_pkg::PROD_W'(cfg.master_fraction) * bstl_pkg::PROD_W'(cfg.area_h);
		div_d   = cmd.div_sel_tile ? NW'(n_q - m_q) : m_q;
	end

	bstl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cfg.area_w),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		has_tiles      = (n_q != m_q);
		in_tile        = (i_q >= m_q);
		win_last       = (i_q == NW'(n_q - 1'b1));
		cross_last     = (i_q == NW'(m_q - 1'b1));
		row_last       = in_tile ? win_last : cross_last;
		next_row_start = (NW'(i_q + 1'b1) == m_q);
		cross_needed   = has_tiles && (m_q != NW'(1));

		// leftover width of the last window in a row, floored at zero
		end_x  = {1'b0, cfg.area_x} + {1'b0, cfg.area_w};
		rem_w  = $signed({{(XW-CW){1'b0}}, end_x}) - $signed({1'b0, nx_q});
		nw_sat = rem_w[XW] ? '0 : rem_w[CW-1:0];
		nw     = row_last ? nw_sat : (in_tile ? tw_q : mw_q);

		ay     = {1'b0, cfg.area_y};
		tile_y = ay + {1'b0, mh_q};
		row_y  = in_tile ? tile_y : ay;
		row_h  = in_tile ? (cfg.area_h - mh_q) : mh_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= n_sat;
			m_q <= m_clamp;
		end
		if (cmd.setup) begin
			mh_q <= has_tiles ? prod[bstl_pkg::PROD_W-1:bstl_pkg::FRAC_W] : cfg.area_h;
			i_q  <= '0;
			nx_q <= XW'(cfg.area_x);
		end
		if (cmd.cap_mw)
			mw_q <= quot;
		if (cmd.cap_tw)
			tw_q <= quot;
		priority if (cmd.emit_win) begin
			priority if (win_last) begin
				// first cross column follows the first master window
				nx_q <= XW'(cfg.area_x) + XW'(mw_q);
				i_q  <= NW'(1);
			end else if (next_row_start) begin
				nx_q <= XW'(cfg.area_x);
				i_q  <= NW'(i_q + 1'b1);
			end else begin
				nx_q <= nx_q + XW'(nw);
				i_q  <= NW'(i_q + 1'b1);
			end
		end else if (cmd.emit_sep) begin
			nx_q <= nx_q + 1'b1;
		end else if (cmd.emit_cross) begin
			nx_q <= nx_q + XW'(mw_q) + 1'b1;
			i_q  <= NW'(i_q + 1'b1);
		end else begin
		end
	end

	// result register
	assign emit    = cmd.emit_zero | cmd.emit_win | cmd.emit_sep | cmd.emit_cross;
	assign emit_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_zero) begin
			kind_q   <= bstl_pkg::KIND_NONE;
			idx_q    <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			last_q   <= 1'b1;
		end else if (cmd.emit_win) begin
			kind_q   <= bstl_pkg::KIND_WINDOW;
			idx_q    <= i_q[bstl_pkg::IDX_W-1:0];
			pos_x_q  <= nx_q[CW-1:0];
			pos_y_q  <= row_y;
			width_q  <= nw;
			height_q <= row_h;
			last_q   <= win_last && !cross_needed;
		end else if (cmd.emit_sep) begin
			kind_q   <= bstl_pkg::KIND_SEP;
			idx_q    <= i_q[bstl_pkg::IDX_W-1:0];
			pos_x_q  <= nx_q[CW-1:0];
			pos_y_q  <= row_y - 1'b1;
			width_q  <= '0;
			height_q <= row_h;
			last_q   <= 1'b0;
		end else if (cmd.emit_cross) begin
			kind_q   <= bstl_pkg::KIND_CROSS;
			idx_q    <= i_q[bstl_pkg::IDX_W-1:0];
			pos_x_q  <= nx_q[CW-1:0];
			pos_y_q  <= tile_y - 1'b1;
			width_q  <= '0;
			height_q <= '0;
			last_q   <= cross_last;
		end else begin
		end
	end

	always_comb begin
		sts.in_zero        = (window_count == '0);
		sts.emit_ok        = emit_ok;
		sts.div_done       = div_done;
		sts.has_tiles      = has_tiles;
		sts.win_last       = win_last;
		sts.next_row_start = next_row_start;
		sts.cross_needed   = cross_needed;
		sts.cross_last     = cross_last;
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign window_index = idx_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign width        = width_q;
	assign height       = height_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bottom_stack_tile_layout.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bottom_stack_tile_layout
// places a number of windows in a master row on top and a tile row below
// ----------------------------------------------------------------------------
// one input item carries a window count; the block answers with a stream of
// result items (window rectangles, separators with a top tee, cross marks),
// the final one flagged by last. a count of zero gives a single empty item.
// after an item is taken, a setup state finds the master row height from an
// 8x10 multiply; then come the master width division (ten quotient bits, then
// a completion flag) and, when a tile row exists, the tile width division,
// both on one shared restoring divider that retires a quotient bit per cycle.
// results then leave at one per cycle while out_ready is high. the block works
// on one item at a time; in_ready rises again as soon as the last result sits
// in the output register, so setup of the next item overlaps with that result
// waiting downstream.
// configuration writes land at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module bottom_stack_tile_layout (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_we,
	input  wire logic [bstl_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [bstl_pkg::COORD_W-1:0]          cfg_wdata,
	// request items
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [bstl_pkg::CNT_W-1:0]            window_count,
	// result items
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [1:0]                                 kind,
	output logic [bstl_pkg::IDX_W-1:0]                 window_index,
	output logic [bstl_pkg::COORD_W-1:0]               pos_x,
	output logic signed [bstl_pkg::POS_Y_W-1:0]        pos_y,
	output logic [bstl_pkg::COORD_W-1:0]               width,
	output logic [bstl_pkg::COORD_W-1:0]               height,
	output logic                                       last
);

	bstl_pkg::cfg_t    cfg;
	bstl_pkg::dp_cmd_t cmd;
	bstl_pkg::dp_sts_t sts;

	// area, master count and fraction
	bstl_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer
	bstl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, column walk and output register
	bstl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.window_count (window_count),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.window_index (window_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.width        (width),
		.height       (height),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== bench/bottom_stack_tile_layout_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bottom_stack_tile_layout_test
// self-checking bench for the bottom-stack tile layout block
// ----------------------------------------------------------------------------
// a queue of window counts feeds a clocked driver; every accepted request is
// laid out by a behavioural model of the master row and tile row, and the
// placements it yields wait in order for the monitor, which compares each
// result item field by field. the run walks through several register
// settings (reset values, both extremes, odd offsets that wrap), then random
// settings with random counts. both sides idle at random, and the receiver
// now and then holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module bottom_stack_tile_layout_test;

	timeunit 1ns;
	timeprecision 1ps;

	import bstl_pkg::*;

	// register indexes past the end of the list, writes to them are dropped
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 23;
	localparam int LONG_HOLD       = 300;
	localparam int HOLD_SPACING    = 1400;
	localparam int QUIET_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 80;

	// one placement as the block should report it
	typedef struct {
		kind_t              kind;
		logic [IDX_W-1:0]   win_index;
		logic [COORD_W-1:0] x;
		logic signed [POS_Y_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic               fin;
	} placement_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
	logic [COORD_W-1:0]    cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [CNT_W-1:0]      window_count = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [1:0]            kind;
	logic [IDX_W-1:0]      window_index;
	logic [COORD_W-1:0]    pos_x;
	logic signed [POS_Y_W-1:0] pos_y;
	logic [COORD_W-1:0]    width;
	logic [COORD_W-1:0]    height;
	logic                  last;

	// the bench's own copy of the layout registers
	logic [COORD_W-1:0] cur_area_x          = RST_AREA_X;
	logic [COORD_W-1:0] cur_area_y          = RST_AREA_Y;
	logic [COORD_W-1:0] cur_area_w          = RST_AREA_W;
	logic [COORD_W-1:0] cur_area_h          = RST_AREA_H;
	logic [CNT_W-1:0]   cur_master_count    = RST_MASTER_COUNT;
	logic [FRAC_W-1:0]  cur_master_fraction = RST_MASTER_FRACTION;

	logic [CNT_W-1:0] pending_counts[$];
	placement_t       expected_layout[$];
	placement_t       want;

	int  queued_count   = 0;
	int  accepted_count = 0;
	int  results_taken  = 0;
	int  mismatches     = 0;
	int  quiet_cycles   = 0;
	int  send_gap       = 0;
	int  send_calm      = 0;
	int  take_gap       = 0;
	int  take_calm      = 0;
	int  hold_left      = 0;
	int  next_hold_at   = 100;
	bit  offer;
	bit  take_next;

	bottom_stack_tile_layout dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.window_count (window_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.window_index (window_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.width        (width),
		.height       (height),
		.last         (last)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// layout model
	// ------------------------------------------------------------------------

	// positions wrap to the field widths, widths and heights stop at zero
	function automatic void add_result(kind_t k, int idx, int x, int y, int w, int h, bit fin);
		placement_t r;
		r.kind      = k;
		r.win_index = idx[IDX_W-1:0];
		r.x         = x[COORD_W-1:0];
		r.y         = y[POS_Y_W-1:0];
		r.w         = (w < 0) ? '0 : w[COORD_W-1:0];
		r.h         = (h < 0) ? '0 : h[COORD_W-1:0];
		r.fin       = fin;
		expected_layout.push_back(r);
	endfunction

	function automatic void predict_layout(logic [CNT_W-1:0] count);
		int n, m, i;
		int mh, mw, tw;
		int lax, lay, law, lah;
		int nx, ny, nh, nw;
		bit crosses;
		n = count;
		if (n > MAX_WINDOWS)
			n = MAX_WINDOWS;
		// an empty screen still answers with one blank item
		if (n == 0) begin
			add_result(KIND_NONE, 0, 0, 0, 0, 0, 1'b1);
			return;
		end
		lax = int'(cur_area_x);
		lay = int'(cur_area_y) - 1;
		law = int'(cur_area_w);
		lah = int'(cur_area_h);
		m = int'(cur_master_count);
		if (m > n)
			m = n;
		if (m < 1)
			m = 1;
		// master row takes the whole height when there is no tile row
		mh = (n == m) ? lah : ((int'(cur_master_fraction) * lah) >> 8);
		mw = law / m;
		tw = (n == m) ? 0 : law / (n - m);
		// with a tile row and more than one master, cross marks close the list
		crosses = (n > m) && (m > 1);
		nx = lax;
		ny = lay;
		nh = mh;
		for (i = 0; i < n; i++) begin
			if (i < m) begin
				if (i > 0) begin
					add_result(KIND_SEP, i, nx, ny, 0, nh, 1'b0);
					nx++;
				end
				nh = mh;
				nw = (i < m - 1) ? mw : (lax + law) - nx;
			end else begin
				if (i == m) begin
					nx = lax;
					ny += mh;
					nh = (lay + lah) - ny;
				end else begin
					add_result(KIND_SEP, i, nx, ny, 0, nh, 1'b0);
					nx++;
				end
				nw = (i < n - 1) ? tw : (lax + law) - nx;
			end
			if (nw < 0)
				nw = 0;
			add_result(KIND_WINDOW, i, nx, ny + 1, nw, nh, (i == n - 1) && !crosses);
			nx += nw;
		end
		if (n > m) begin
			nx = lax;
			for (i = 0; i < m; i++) begin
				if (i > 0) begin
					add_result(KIND_CROSS, i, nx, ny, 0, 0, i == m - 1);
					nx++;
				end
				nw = (i < m - 1) ? mw : (lax + law) - nx;
				if (nw < 0)
					nw = 0;
				nx += nw;
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// helpers for pacing, stimulus and checks
	// ------------------------------------------------------------------------

	// idle cycles before the next item, with runs of back-to-back items now and then
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// counts beyond the window limit are drawn now and then to exercise saturation
	function automatic logic [CNT_W-1:0] draw_count();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return CNT_W'($urandom_range(MAX_WINDOWS + 1, 31));
		return CNT_W'($urandom_range(1, MAX_WINDOWS));
	endfunction

	// register values lean towards the ends of their range
	function automatic logic [COORD_W-1:0] draw_reg_value(int lo, int hi);
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return COORD_W'(lo);
		if (sel == 1)
			return COORD_W'(hi);
		if (sel == 2)
			return COORD_W'($urandom_range(lo, lo + 20));
		return COORD_W'($urandom_range(lo, hi));
	endfunction

	function automatic void queue_count(logic [CNT_W-1:0] c);
		pending_counts.push_back(c);
		queued_count++;
	endfunction

	function automatic void compare_field(string name, logic signed [15:0] want_v,
			logic signed [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// registers are only touched while the block is idle
	task automatic write_layout_reg(logic [CFG_ADDR_W-1:0] idx, logic [COORD_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_AREA_X:          cur_area_x          = value;
			REG_AREA_Y:          cur_area_y          = value;
			REG_AREA_W:          cur_area_w          = value;
			REG_AREA_H:          cur_area_h          = value;
			REG_MASTER_COUNT:    cur_master_count    = value[CNT_W-1:0];
			REG_MASTER_FRACTION: cur_master_fraction = value[FRAC_W-1:0];
			default:             ;
		endcase
	endtask

	// every request taken and every placement seen, then a short pause
	task automatic wait_until_drained();
		while (accepted_count != queued_count || expected_layout.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			window_count <= '0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				// registers are stable here, so the layout is worked out at once
				predict_layout(window_count);
				accepted_count++;
				offer    = 1'b0;
				send_gap = draw_wait(send_calm);
			end
			// a new item may follow in the same cycle when no gap was drawn
			if (!offer && pending_counts.size() != 0) begin
				if (send_gap > 0) begin
					send_gap--;
				end else begin
					window_count <= pending_counts.pop_front();
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// ------------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_layout.size() == 0) begin
					$display("%0t: unexpected item, kind %0d index %0d x %0d y %0d w %0d h %0d last %0b",
						$time, kind, window_index, pos_x, pos_y, width, height, last);
					mismatches++;
				end else begin
					want = expected_layout.pop_front();
					compare_field("kind", want.kind, kind);
					compare_field("window_index", want.win_index, window_index);
					compare_field("pos_x", want.x, pos_x);
					compare_field("pos_y", want.y, pos_y);
					compare_field("width", want.w, width);
					compare_field("height", want.h, height);
					compare_field("last", want.fin, last);
				end
				results_taken++;
				take_gap = draw_wait(take_calm);
				// long hold-off while the sender still has an item on offer
				if (results_taken >= next_hold_at && in_valid) begin
					hold_left    = LONG_HOLD;
					next_hold_at += HOLD_SPACING;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				take_next = 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				take_next = 1'b0;
			end else begin
				take_next = 1'b1;
			end
			out_ready <= take_next;
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any handshake or register write
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty request, single master, saturating counts
		queue_count(0);  queue_count(1);  queue_count(2);  queue_count(3);
		queue_count(16); queue_count(17); queue_count(31); queue_count(4);
		wait_until_drained();

		// top of every range but area_y, which sits at its bottom: positions wrap, area starts on row zero
		write_layout_reg(REG_AREA_X, 10'd1023);
		write_layout_reg(REG_AREA_Y, 10'd0);
		write_layout_reg(REG_AREA_W, 10'd1023);
		write_layout_reg(REG_AREA_H, 10'd1023);
		write_layout_reg(REG_MASTER_COUNT, 10'd16);
		write_layout_reg(REG_MASTER_FRACTION, 10'd255);
		queue_count(16); queue_count(31); queue_count(9); queue_count(1);
		wait_until_drained();

		// bottom of every range but area_y, which sits at its top: one-cell area so widths run out, masters forced to one
		write_layout_reg(REG_AREA_X, 10'd0);
		write_layout_reg(REG_AREA_Y, 10'd1023);
		write_layout_reg(REG_AREA_W, 10'd1);
		write_layout_reg(REG_AREA_H, 10'd1);
		write_layout_reg(REG_MASTER_COUNT, 10'd0);
		write_layout_reg(REG_MASTER_FRACTION, 10'd0);
		// writes past the register list must leave everything alone
		write_layout_reg(CFG_SPARE_LO, 10'h3FF);
		write_layout_reg(CFG_SPARE_HI, 10'h2AA);
		queue_count(16); queue_count(2); queue_count(1); queue_count(0);
		wait_until_drained();

		// several masters with a tile row, columns wrapping past the right edge
		write_layout_reg(REG_AREA_X, 10'd1000);
		write_layout_reg(REG_AREA_Y, 10'd500);
		write_layout_reg(REG_AREA_W, 10'd100);
		write_layout_reg(REG_AREA_H, 10'd40);
		write_layout_reg(REG_MASTER_COUNT, 10'd3);
		write_layout_reg(REG_MASTER_FRACTION, 10'd200);
		queue_count(2); queue_count(3); queue_count(4); queue_count(7); queue_count(16);
		wait_until_drained();

		// random settings, each followed by a batch of random counts
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_layout_reg(REG_AREA_X, draw_reg_value(0, 1023));
			write_layout_reg(REG_AREA_Y, draw_reg_value(0, 1023));
			write_layout_reg(REG_AREA_W, draw_reg_value(1, 1023));
			write_layout_reg(REG_AREA_H, draw_reg_value(1, 1023));
			write_layout_reg(REG_MASTER_COUNT, draw_reg_value(0, MAX_WINDOWS));
			write_layout_reg(REG_MASTER_FRACTION, draw_reg_value(0, 255));
			if ($urandom_range(0, 3) == 0)
				write_layout_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					COORD_W'($urandom));
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				queue_count(draw_count());
			wait_until_drained();
		end

		// let any stray item show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_layout.size() != 0) begin
			$display("%0t: %0d placements never arrived", $time, expected_layout.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/bstl_pkg.sv
hw/rtl/bstl_regs.sv
hw/rtl/bstl_div.sv
hw/rtl/bstl_ctrl.sv
hw/rtl/bstl_dp.sv
hw/rtl/bottom_stack_tile_layout.sv
bench/bottom_stack_tile_layout_test.sv
